// ===== rtl/core/emw_pkg.sv =====
// Shared constants, widths and a helper function for the energy meter window block.
// Used by every module under rtl/core; depends on nothing.
package emw_pkg;

  // Window length in sample pairs.
  localparam int unsigned SAMPLES = 64;

  // Sample and register widths.
  localparam int unsigned SMP_W = 13;
  localparam int unsigned RES_W = 10;
  localparam int unsigned CNT_W = $clog2(SAMPLES);

  // Accumulator width: holds 4 * SAMPLES * 8191^2 for the largest window.
  localparam int unsigned ACC_W = 40;

  // Serial multiplier: the multiplier operand is shifted out one bit per cycle.
  localparam int unsigned MUL_A_W = SMP_W;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Serial divider: one quotient bit per cycle over the full accumulator width.
  localparam int unsigned PWR_DIV = 4 * SAMPLES * 10000;
  localparam int unsigned DIV_D_W = $clog2(PWR_DIV + 1);
  localparam int unsigned RMS_DIV = 100;

  // Square root: two radicand bits per cycle.
  localparam int unsigned ROOT_W = ACC_W / 2;

  // Constants of the result scaling.
  localparam int unsigned INV_SQRT2_Q16 = 46341;
  localparam int unsigned Q16_SHIFT = 16;
  localparam int unsigned SAT_MAX = 999;
  localparam int unsigned OFFSET_RESET = 2100;

  // Configuration port.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_OFFSET_IDX = 1'b0;

  // Saturates a wide unsigned value at the largest result.
  function automatic logic [RES_W-1:0] sat_fn(input logic [ACC_W-1:0] val);
    logic [RES_W-1:0] res;
    if (val > ACC_W'(SAT_MAX)) begin
      res = RES_W'(SAT_MAX);
    end else begin
      res = val[RES_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/emw_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on emw_pkg for operand widths.
module emw_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [emw_pkg::MUL_A_W-1:0] a_i,
  input  logic [emw_pkg::MUL_B_W-1:0] b_i,
  output logic                        done_o,
  output logic [emw_pkg::MUL_P_W-1:0] prod_o
);

  localparam int unsigned MulCntW = $clog2(emw_pkg::MUL_A_W);

  logic [emw_pkg::MUL_P_W:0]   p_q, p_d;
  logic [emw_pkg::MUL_B_W-1:0] b_q;
  logic [emw_pkg::MUL_B_W:0]   hi_sum;
  logic [MulCntW-1:0]          cnt_q;
  logic                        busy_q;
  logic                        done_q;

  // Upper half plus the multiplicand when the current multiplier bit is set.
  assign hi_sum = p_q[emw_pkg::MUL_P_W:emw_pkg::MUL_A_W]
                + (p_q[0] ? {1'b0, b_q} : '0);
  assign p_d    = {1'b0, hi_sum, p_q[emw_pkg::MUL_A_W-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MulCntW'(emw_pkg::MUL_A_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= {{(emw_pkg::MUL_B_W + 1){1'b0}}, a_i};
      b_q <= b_i;
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q[emw_pkg::MUL_P_W-1:0];

endmodule

// ===== rtl/core/emw_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on emw_pkg for the dividend and divisor widths.
module emw_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [emw_pkg::ACC_W-1:0]   dividend_i,
  input  logic [emw_pkg::DIV_D_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [emw_pkg::ACC_W-1:0]   quo_o
);

  localparam int unsigned DivCntW = $clog2(emw_pkg::ACC_W);

  logic [emw_pkg::DIV_D_W-1:0] rem_q;
  logic [emw_pkg::DIV_D_W-1:0] dvs_q;
  logic [emw_pkg::ACC_W-1:0]   quo_q;
  logic [emw_pkg::DIV_D_W:0]   trial;
  logic [emw_pkg::DIV_D_W:0]   diff;
  logic                        fits;
  logic [DivCntW-1:0]          cnt_q;
  logic                        busy_q;
  logic                        done_q;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign trial = {rem_q, quo_q[emw_pkg::ACC_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(emw_pkg::ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[emw_pkg::DIV_D_W-1:0] : trial[emw_pkg::DIV_D_W-1:0];
      quo_q <= {quo_q[emw_pkg::ACC_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/core/emw_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on emw_pkg for the radicand and root widths.
module emw_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [emw_pkg::ACC_W-1:0]  rad_i,
  output logic                       done_o,
  output logic [emw_pkg::ROOT_W-1:0] root_o
);

  localparam int unsigned SqCntW = $clog2(emw_pkg::ROOT_W);
  localparam int unsigned RemW   = emw_pkg::ROOT_W + 2;

  logic [emw_pkg::ACC_W-1:0]  rad_q;
  logic [emw_pkg::ROOT_W-1:0] root_q;
  logic [RemW-1:0]            rem_q;
  logic [RemW+1:0]            cand;
  logic [RemW+1:0]            trial;
  logic [RemW+1:0]            diff;
  logic                       fits;
  logic [SqCntW-1:0]          cnt_q;
  logic                       busy_q;
  logic                       done_q;

  // The partial remainder stays below twice the partial root, so it fits RemW bits.
  assign cand  = {rem_q, rad_q[emw_pkg::ACC_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign diff  = cand - trial;
  assign fits  = (cand >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SqCntW'(emw_pkg::ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[emw_pkg::ACC_W-3:0], 2'b00};
      root_q <= {root_q[emw_pkg::ROOT_W-2:0], fits};
      rem_q  <= fits ? diff[RemW-1:0] : cand[RemW-1:0];
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/energy_meter_window_top.sv =====
// Energy meter window: real power, RMS voltage and peak current over windows of pairs.
// A pair that does not close a window takes two passes of the bit-serial multiplier
// before the next pair can be taken. The closing pair then takes three divider
// passes, the square root and two more multiplier passes.
// Reset: asynchronous, active low; clears the window and sets the offset to 2100 mV.
module energy_meter_window_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [emw_pkg::APB_AW-1:0] paddr,
  input  logic [emw_pkg::APB_DW-1:0] pwdata,
  output logic [emw_pkg::APB_DW-1:0] prdata,
  output logic                       pready,

  // Sample stream.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [12:0] voltage_mv, [25:13] current_mv, [31:26] zero
  input  logic [31:0]                s_axis_tdata,

  // Result stream.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [9:0] rms_tenths_volt, [19:10] peak_current_ma, [29:20] power_hundredths_watt,
  // [31:30] zero
  output logic [31:0]                m_axis_tdata
);

  localparam int unsigned SW = emw_pkg::SMP_W;
  localparam int unsigned RW = emw_pkg::RES_W;
  localparam int unsigned AW = emw_pkg::ACC_W;

  // The sequencer walks one arithmetic unit at a time through the work of a word.
  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_MUL_PWR  = 10'b00_0000_0010,
    S_MUL_SQ   = 10'b00_0000_0100,
    S_MUL_WRAP = 10'b00_0000_1000,
    S_DIV_SQ   = 10'b00_0001_0000,
    S_SQRT     = 10'b00_0010_0000,
    S_DIV_RMS  = 10'b00_0100_0000,
    S_MUL_PEAK = 10'b00_1000_0000,
    S_DIV_PWR  = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   go_q;

  logic [SW-1:0]               offset_q;
  logic [emw_pkg::CNT_W-1:0]   cnt_q;
  logic [SW-1:0]               first_v_q;
  logic [SW-1:0]               prev_i_q;
  logic [SW-1:0]               v_q;
  logic [SW-1:0]               i_q;
  logic [SW-1:0]               peak_q;
  logic [AW-1:0]               pwr_sum_q;
  logic [AW-1:0]               sq_sum_q;
  logic [AW-1:0]               work_q;
  logic [RW-1:0]               rms_res_q;
  logic [RW-1:0]               peak_res_q;
  logic [RW-1:0]               pwr_res_q;
  logic                        out_valid_q;
  logic [31:0]                 out_data_q;

  logic [SW-1:0]               in_v;
  logic [SW-1:0]               in_i;
  logic                        in_fire;
  logic                        out_fire;
  logic                        last_pair;
  logic                        emit;
  logic                        cfg_wr;
  logic [SW-1:0]               peak_above;

  // Arithmetic unit connections.
  logic                        mul_start;
  logic [emw_pkg::MUL_A_W-1:0] mul_a;
  logic [emw_pkg::MUL_B_W-1:0] mul_b;
  logic                        mul_done;
  logic [emw_pkg::MUL_P_W-1:0] mul_prod;
  logic [AW-1:0]               mul_twice;
  logic                        div_start;
  logic [AW-1:0]               div_dividend;
  logic [emw_pkg::DIV_D_W-1:0] div_divisor;
  logic                        div_done;
  logic [AW-1:0]               div_quo;
  logic                        sqrt_start;
  logic                        sqrt_done;
  logic [emw_pkg::ROOT_W-1:0]  sqrt_root;

  // Configuration register: one offset register, decoded on the word address.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == emw_pkg::REG_OFFSET_IDX);
  assign prdata = (paddr[2] == emw_pkg::REG_OFFSET_IDX)
                ? {{(emw_pkg::APB_DW - SW){1'b0}}, offset_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= SW'(emw_pkg::OFFSET_RESET);
    end else if (cfg_wr) begin
      offset_q <= pwdata[SW-1:0];
    end
  end

  // Handshakes. A finished result waits in the output register while the
  // next window is gathered; only the closing step waits for it to drain.
  assign in_v          = s_axis_tdata[SW-1:0];
  assign in_i          = s_axis_tdata[2*SW-1:SW];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign last_pair     = (cnt_q == emw_pkg::CNT_W'(emw_pkg::SAMPLES - 1));
  assign emit          = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // Peak current above the offset, clamped at zero.
  assign peak_above = (peak_q > offset_q) ? (peak_q - offset_q) : '0;
  assign mul_twice  = {{(AW - emw_pkg::MUL_P_W - 1){1'b0}}, mul_prod, 1'b0};

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_fire) state_d = S_MUL_PWR;
      S_MUL_PWR:  if (mul_done) state_d = S_MUL_SQ;
      S_MUL_SQ: begin
        if (mul_done) state_d = last_pair ? S_MUL_WRAP : S_IDLE;
      end
      S_MUL_WRAP: if (mul_done) state_d = S_DIV_SQ;
      S_DIV_SQ:   if (div_done) state_d = S_SQRT;
      S_SQRT:     if (sqrt_done) state_d = S_DIV_RMS;
      S_DIV_RMS:  if (div_done) state_d = S_MUL_PEAK;
      S_MUL_PEAK: if (mul_done) state_d = S_DIV_PWR;
      S_DIV_PWR:  if (div_done) state_d = S_DONE;
      S_DONE:     if (emit) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_a        = v_q;
    mul_b        = emw_pkg::MUL_B_W'(v_q);
    div_dividend = sq_sum_q;
    div_divisor  = emw_pkg::DIV_D_W'(emw_pkg::SAMPLES);
    unique case (state_q)
      S_MUL_PWR: begin
        // The cross term with the previous current is left out on the first pair.
        mul_b = emw_pkg::MUL_B_W'({1'b0, i_q}
              + ((cnt_q == '0) ? {(SW + 1){1'b0}} : {1'b0, prev_i_q}));
      end
      S_MUL_WRAP: begin
        mul_a = first_v_q;
        mul_b = emw_pkg::MUL_B_W'(i_q);
      end
      S_MUL_PEAK: begin
        mul_a = peak_above;
        mul_b = emw_pkg::MUL_B_W'(emw_pkg::INV_SQRT2_Q16);
      end
      S_DIV_RMS: begin
        div_dividend = work_q;
        div_divisor  = emw_pkg::DIV_D_W'(emw_pkg::RMS_DIV);
      end
      S_DIV_PWR: begin
        div_dividend = pwr_sum_q;
        div_divisor  = emw_pkg::DIV_D_W'(emw_pkg::PWR_DIV);
      end
      default: begin
      end
    endcase
  end

  // Each compute state starts its unit in its first cycle.
  assign mul_start  = go_q && ((state_q == S_MUL_PWR) || (state_q == S_MUL_SQ)
                    || (state_q == S_MUL_WRAP) || (state_q == S_MUL_PEAK));
  assign div_start  = go_q && ((state_q == S_DIV_SQ) || (state_q == S_DIV_RMS)
                    || (state_q == S_DIV_PWR));
  assign sqrt_start = go_q && (state_q == S_SQRT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      go_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= (state_d != state_q) && (state_d != S_IDLE) && (state_d != S_DONE);
    end
  end

  // Window state. Every window starts from cleared accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      first_v_q <= '0;
      prev_i_q  <= '0;
      peak_q    <= '0;
      pwr_sum_q <= '0;
      sq_sum_q  <= '0;
    end else begin
      if (in_fire) begin
        if (cnt_q == '0) begin
          first_v_q <= in_v;
        end
        if (in_i > peak_q) begin
          peak_q <= in_i;
        end
      end
      if (mul_done && ((state_q == S_MUL_PWR) || (state_q == S_MUL_WRAP))) begin
        pwr_sum_q <= pwr_sum_q + mul_twice;
      end
      if (mul_done && (state_q == S_MUL_SQ)) begin
        sq_sum_q <= sq_sum_q + AW'(mul_prod);
        prev_i_q <= i_q;
        if (!last_pair) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (emit) begin
        cnt_q     <= '0;
        first_v_q <= '0;
        prev_i_q  <= '0;
        peak_q    <= '0;
        pwr_sum_q <= '0;
        sq_sum_q  <= '0;
      end
    end
  end

  // Sample and intermediate registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      v_q <= in_v;
      i_q <= in_i;
    end
    if (div_done && (state_q == S_DIV_SQ)) begin
      work_q <= div_quo;
    end
    if (sqrt_done) begin
      work_q <= AW'(sqrt_root);
    end
    if (div_done && (state_q == S_DIV_RMS)) begin
      rms_res_q <= emw_pkg::sat_fn(div_quo);
    end
    if (mul_done && (state_q == S_MUL_PEAK)) begin
      peak_res_q <= emw_pkg::sat_fn(AW'(mul_prod[emw_pkg::MUL_P_W-1:emw_pkg::Q16_SHIFT]));
    end
    if (div_done && (state_q == S_DIV_PWR)) begin
      pwr_res_q <= emw_pkg::sat_fn(div_quo);
    end
    if (emit) begin
      out_data_q <= {2'b00, pwr_res_q, peak_res_q, rms_res_q};
    end
  end

  // Output valid: set when the results are loaded, cleared once the word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  emw_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  emw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  emw_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (work_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

endmodule

// ===== test/tb_energy_meter_window_top.sv =====
// Self-checking testbench for energy_meter_window_top: sample stream in, one meter word per window.
// Holds its own window predictor; depends only on emw_pkg and the block itself.
`timescale 1ns / 100ps

module tb_energy_meter_window_top;
  localparam int unsigned SAMPLES = emw_pkg::SAMPLES;
  localparam int unsigned SMP_W = emw_pkg::SMP_W;
  localparam int unsigned RES_W = emw_pkg::RES_W;

  // Register indexes of the configuration port; index 1 is not decoded by the block.
  localparam int unsigned OFFSET_REG = 0;
  localparam int unsigned SPARE_REG = 1;

  // Scaling constants of the meter arithmetic.
  localparam int unsigned CLIP_MAX = 999;
  localparam longint unsigned INV_SQRT2_Q16 = 46341;
  localparam longint unsigned PWR_SCALE = 4 * SAMPLES * 10000;

  // Cycles to let pass once the last expected word is in: the closing pair is the slow one.
  localparam int unsigned SETTLE_CYCLES = 250;
  // Long receiver hold-off, and the watchdog limit on cycles with no handshake at all. The
  // hold-off outlasts two full windows, so a second finished word backs up behind the first.
  localparam int unsigned HOLD_CYCLES = 8000;
  localparam int unsigned QUIET_LIMIT = 20000;

  // One meter word, lowest field in the lowest bits as on m_axis_tdata.
  typedef struct packed {
    logic [RES_W-1:0] pwr;
    logic [RES_W-1:0] peak;
    logic [RES_W-1:0] rms;
  } meter_t;

  // One directed window: a constant pair everywhere except an optional spike pair.
  typedef struct {
    logic [SMP_W-1:0] volt;
    logic [SMP_W-1:0] amp;
    int               spike_at;
    logic [SMP_W-1:0] spike_volt;
    logic [SMP_W-1:0] spike_amp;
    bit               typed;
    meter_t           want;
  } window_row_t;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Configuration port.
  logic        apb_sel = 1'b0;
  logic        apb_enable = 1'b0;
  logic        apb_write = 1'b0;
  logic [2:0]  apb_addr = '0;
  logic [31:0] apb_wdata = '0;
  logic [31:0] apb_rdata;
  logic        apb_ready;

  // Sample and result streams.
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // [12:0] voltage_mv, [25:13] current_mv, [31:26] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // [9:0] rms, [19:10] peak current, [29:20] power, [31:30] zero

  // Expected meter words, oldest first, and the failure count.
  meter_t      meter_q[$];
  int unsigned fail_count = 0;

  // Predictor copy of the block: offset register and the open window.
  logic [SMP_W-1:0] offset_mv = SMP_W'(2100);
  int unsigned      win_count = 0;
  logic [SMP_W-1:0] win_first_v = '0;
  logic [SMP_W-1:0] win_prev_i = '0;
  logic [SMP_W-1:0] win_peak = '0;
  longint unsigned  win_power = 0;
  longint unsigned  win_squares = 0;

  // While set, a window that closes takes the hand-typed word instead of the predicted one.
  bit     typed_on = 1'b0;
  meter_t typed_want = '0;

  // Idling controls, set by the stimulus process per phase.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  window_row_t dir_rows [9];

  energy_meter_window_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (apb_sel),
    .penable       (apb_enable),
    .pwrite        (apb_write),
    .paddr         (apb_addr),
    .pwdata        (apb_wdata),
    .prdata        (apb_rdata),
    .pready        (apb_ready),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  // 12 ns clock.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Floor of the square root, two radicand bits per step.
  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem = x;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [RES_W-1:0] clip999(input longint unsigned x);
    return (x > CLIP_MAX) ? RES_W'(CLIP_MAX) : RES_W'(x);
  endfunction

  // Folds one accepted pair into the window. When the pair closes the window, the meter word
  // is returned and the window starts over from cleared accumulators.
  function automatic bit take_pair(input logic [SMP_W-1:0] volt, input logic [SMP_W-1:0] amp,
                                   output meter_t res);
    longint unsigned peak_q;
    res = '0;
    if (win_count == 0) begin
      win_first_v = volt;
    end else begin
      win_power += 64'(volt) * 64'(win_prev_i) * 2;
    end
    win_power += 64'(volt) * 64'(amp) * 2;
    win_squares += 64'(volt) * 64'(volt);
    if (amp > win_peak) win_peak = amp;
    win_prev_i = amp;
    if (win_count + 1 < SAMPLES) begin
      win_count++;
      return 1'b0;
    end
    // The wrap term pairs the first voltage of the window with its last current.
    win_power += 64'(win_first_v) * 64'(amp) * 2;
    peak_q = (win_peak > offset_mv) ? 64'(win_peak - offset_mv) : 64'd0;
    res.rms = clip999(root_floor(win_squares / SAMPLES) / 100);
    res.peak = clip999((peak_q * INV_SQRT2_Q16) >> 16);
    res.pwr = clip999(win_power / PWR_SCALE);
    win_count = 0;
    win_first_v = '0;
    win_prev_i = '0;
    win_peak = '0;
    win_power = 0;
    win_squares = 0;
    return 1'b1;
  endfunction

  function automatic window_row_t make_row(input int volt, input int amp, input int spike_at,
                                           input int spike_volt, input int spike_amp,
                                           input bit typed, input int rms, input int peak,
                                           input int pwr);
    window_row_t row;
    row.volt = SMP_W'(volt);
    row.amp = SMP_W'(amp);
    row.spike_at = spike_at;
    row.spike_volt = SMP_W'(spike_volt);
    row.spike_amp = SMP_W'(spike_amp);
    row.typed = typed;
    row.want.rms = RES_W'(rms);
    row.want.peak = RES_W'(peak);
    row.want.pwr = RES_W'(pwr);
    return row;
  endfunction

  // A sample value: mostly the nominal range, with full-scale, small and near-offset values.
  function automatic logic [SMP_W-1:0] draw_mv();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return SMP_W'($urandom_range(5000));
    if (pick < 65) return SMP_W'($urandom());
    if (pick < 80) return SMP_W'($urandom_range(300));
    if (pick < 92) return SMP_W'($urandom_range(2300, 1900));
    return pick[0] ? {SMP_W{1'b1}} : '0;
  endfunction

  // Offers one sample word, called and returning at a falling edge. A gap may come first; the
  // word then stays valid until the block takes it, and the predictor runs at that edge.
  task automatic push_pair(input logic [SMP_W-1:0] volt, input logic [SMP_W-1:0] amp);
    meter_t res;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(48, 1)) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, amp, volt};
    do @(posedge clk_i); while (!s_tready);
    if (take_pair(volt, amp, res)) begin
      meter_q.push_back(typed_on ? typed_want : res);
    end
    @(negedge clk_i);
  endtask

  // Drops the sample valid in the current falling-edge step.
  task automatic tx_quiet();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (meter_q.size() != 0) @(posedge clk_i);
  endtask

  // One configuration transfer: setup at a falling edge, access at the next one. The transfer
  // completes at the rising edge where pready is seen; the port is left selected so that the
  // next transfer can follow back to back.
  task automatic apb_xfer(input bit wr, input int unsigned idx, input logic [31:0] data,
                          output logic [31:0] rdata);
    @(negedge clk_i);
    apb_sel <= 1'b1;
    apb_enable <= 1'b0;
    apb_write <= wr;
    apb_addr <= 3'(4 * idx);
    apb_wdata <= data;
    @(negedge clk_i);
    apb_enable <= 1'b1;
    do @(posedge clk_i); while (!apb_ready);
    rdata = apb_rdata;
    if (wr && idx == OFFSET_REG) offset_mv = data[SMP_W-1:0];
  endtask

  task automatic apb_release();
    @(negedge clk_i);
    apb_sel <= 1'b0;
    apb_enable <= 1'b0;
    apb_write <= 1'b0;
  endtask

  // Reads the offset back and compares it with the predictor's copy.
  task automatic check_offset();
    logic [31:0] rd;
    apb_xfer(1'b0, OFFSET_REG, '0, rd);
    if (rd !== 32'(offset_mv)) begin
      $display("%0t offset readback: expected %0d, got %0d", $time, offset_mv, rd);
      fail_count++;
    end
  endtask

  // Sets a new offset once the block is idle. The spare register index is written with junk
  // too; the readback afterwards shows that it left the offset alone.
  task automatic reconfigure(input logic [31:0] offset_word);
    logic [31:0] rd;
    tx_quiet();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_xfer(1'b1, OFFSET_REG, offset_word, rd);
    apb_xfer(1'b1, SPARE_REG, $urandom(), rd);
    check_offset();
    apb_release();
  endtask

  // Receiver: random stalls per phase, plus a long hold-off when the stimulus asks for one.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      m_tready <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Result checker and watchdog. A meter word is compared field by field with the oldest
  // expectation; a run with no handshake for too long is a failure.
  always @(posedge clk_i) begin
    meter_t want;
    meter_t got;
    got = m_tdata[3*RES_W-1:0];
    if (rst_ni && m_tvalid && m_tready) begin
      if (meter_q.size() == 0) begin
        $display("%0t unexpected meter word: rms %0d peak %0d power %0d",
                 $time, got.rms, got.peak, got.pwr);
        fail_count++;
      end else begin
        want = meter_q.pop_front();
        if (got.rms !== want.rms) begin
          $display("%0t rms_tenths_volt: expected %0d, got %0d", $time, want.rms, got.rms);
          fail_count++;
        end
        if (got.peak !== want.peak) begin
          $display("%0t peak_current_ma: expected %0d, got %0d", $time, want.peak, got.peak);
          fail_count++;
        end
        if (got.pwr !== want.pwr) begin
          $display("%0t power_hundredths_watt: expected %0d, got %0d",
                   $time, want.pwr, got.pwr);
          fail_count++;
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (apb_sel && apb_enable && apb_ready))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t no handshake for %0d cycles", $time, quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed windows at the reset offset, then random phases with new offsets.
  initial begin
    int unsigned n_items;
    int unsigned amp_cap;
    logic [SMP_W-1:0] volt;
    logic [SMP_W-1:0] amp;

    // Directed windows. Constant windows have a word that is easy to work out by hand:
    // zero input, full scale, nominal full scale, a current at or below the offset (peak
    // clamps to zero) and a small current just above it. The spike windows put the peak
    // or the wrap term on the first, last and a middle pair; the predictor checks those.
    dir_rows[0] = make_row(0, 0, -1, 0, 0, 1'b1, 0, 0, 0);
    dir_rows[1] = make_row(8191, 8191, -1, 0, 0, 1'b1, 81, 999, 999);
    dir_rows[2] = make_row(5000, 5000, -1, 0, 0, 1'b1, 50, 999, 999);
    dir_rows[3] = make_row(1000, 1000, -1, 0, 0, 1'b1, 10, 0, 100);
    dir_rows[4] = make_row(100, 2200, -1, 0, 0, 1'b1, 1, 70, 22);
    dir_rows[5] = make_row(2000, 2100, -1, 0, 0, 1'b1, 20, 0, 420);
    dir_rows[6] = make_row(3000, 500, 0, 8191, 8191, 1'b0, 0, 0, 0);
    dir_rows[7] = make_row(4000, 2500, SAMPLES - 1, 8191, 0, 1'b0, 0, 0, 0);
    dir_rows[8] = make_row(1234, 4321, 17, 0, 5000, 1'b0, 0, 0, 0);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // The offset comes out of reset at 2100 mV.
    @(negedge clk_i);
    check_offset();
    apb_release();

    for (int r = 0; r < $size(dir_rows); r++) begin
      typed_on = dir_rows[r].typed;
      typed_want = dir_rows[r].want;
      for (int k = 0; k < SAMPLES; k++) begin
        if (k == dir_rows[r].spike_at) begin
          push_pair(dir_rows[r].spike_volt, dir_rows[r].spike_amp);
        end else begin
          push_pair(dir_rows[r].volt, dir_rows[r].amp);
        end
      end
    end
    tx_quiet();
    wait_drained();
    @(negedge clk_i);
    typed_on = 1'b0;

    // Random phases. Each starts idle with a new offset (zero, all ones, nominal, random
    // with junk above bit 12, random, reset value) and runs two to four windows, ending
    // mostly inside an open window, so that later reconfigurations land in its middle.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: reconfigure(32'd0);
        1: reconfigure(32'h0000_1FFF);
        2: reconfigure(32'd5000);
        3: reconfigure($urandom() | 32'hFFFF_E000);
        4: reconfigure(32'($urandom_range(8191)));
        default: reconfigure(32'd2100);
      endcase
      case (ph)
        1: begin
          tx_idle_pct = 58;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 58;
        end
        3, 5: begin
          tx_idle_pct = 38;
          rx_stall_pct = 38;
        end
        default: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
      endcase
      // In the first phase the receiver holds off long enough for a finished word to back
      // up and for the block to stop taking samples while the sender keeps offering.
      if (ph == 0) holds_asked++;
      n_items = 2 * SAMPLES + $urandom_range(2 * SAMPLES - 1, 8);
      amp_cap = 8191;
      for (int k = 0; k < n_items; k++) begin
        // Once, the sender stops until every word due so far has come out.
        if (ph == 1 && k == n_items / 2) begin
          tx_quiet();
          wait_drained();
          @(negedge clk_i);
        end
        // Each window gets its own current range, so that the peak lands below, near and
        // far above the offset.
        if (win_count == 0) begin
          case ($urandom_range(3))
            0: amp_cap = 8191;
            1: amp_cap = 3000;
            2: amp_cap = 2400;
            default: amp_cap = 400;
          endcase
        end
        volt = draw_mv();
        amp = (amp_cap == 8191) ? draw_mv() : SMP_W'($urandom_range(amp_cap));
        push_pair(volt, amp);
      end
    end

    tx_quiet();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
